// File: rtl/core/blpg_pkg.sv
// blpg_pkg: shared widths, register indexes and item types of the line pixel generator
// no dependencies; imported by every module under rtl/core
package blpg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int MAX_DIM     = 2048;
    localparam int DIM_BITS    = 12;
    localparam int COLOR_BITS  = 32;
    localparam int OFFSET_BITS = 22;
    localparam int ERR_BITS    = 32;
    localparam int X_BITS      = COORD_BITS + 1;
    localparam int Y_BITS      = COORD_BITS + 2;
    localparam int INC_BITS    = COORD_BITS + 3;
    localparam int WY_BITS     = DIM_BITS + 1 + Y_BITS;
    localparam int AREA_BITS   = 2 * DIM_BITS;
    localparam int QUEUE_DEPTH = 4;

    localparam int PADDR_BITS     = 4;
    localparam int PDATA_BITS     = 32;
    localparam int IN_TDATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((2 + OFFSET_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COLOR  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // classified request handed from front end to back end
    typedef struct packed {
        logic                  is_load;
        logic                  nonempty;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [INC_BITS-1:0]   inc_s;
        logic [INC_BITS-1:0]   inc_d;
        logic [INC_BITS-1:0]   err0;
    } t_cmd;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [COLOR_BITS-1:0] color;
    } t_cfg;

endpackage

// File: rtl/core/bresenham_line_pixel_gen_core.sv
// an accepted request passes the front register, the queue, the state update,
// the clip/multiply stage and the offset add into the output register
// throughput: one request per clock unless results stall, set by the back end's
// error and position update; the queue lets requests be taken while results stall
// reset: synchronous, active low; clears handshake and line-busy state, sets
// screen 640x480 and color 0
module bresenham_line_pixel_gen_core #(
    parameter int QUEUE_DEPTH = blpg_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // x_start, y_start, x_end, y_end (12 bits each, signed)
    input  logic [blpg_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // opcode: 0 load endpoints, 1 step one pixel
    input  logic                                   s_axis_tuser,
    // pixel stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pixel_active, write_enable, pixel_offset (22), pixel_color (32)
    output logic [blpg_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // last_pixel
    output logic                                   m_axis_tlast,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [blpg_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [blpg_pkg::PDATA_BITS-1:0]        pwdata,
    output logic [blpg_pkg::PDATA_BITS-1:0]        prdata,
    output logic                                   pready
);
    import blpg_pkg::*;

    // configuration registers
    logic [DIM_BITS-1:0]   r_width, r_height, n_dim;
    logic [COLOR_BITS-1:0] r_color;
    logic                  cfg_wr;
    t_cfg                  cfg;

    // front end to queue, queue to back end
    logic f_valid, f_ready, q_valid, q_ready;
    t_cmd f_cmd, q_cmd;

    // result fields
    logic                   pix_active, pix_we, pix_last;
    logic [OFFSET_BITS-1:0] pix_offset;
    logic [COLOR_BITS-1:0]  pix_color;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // dimensions saturate at the largest supported screen size
    assign n_dim = (pwdata[DIM_BITS-1:0] > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM)
                                                               : pwdata[DIM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(640);
            r_height <= DIM_BITS'(480);
            r_color  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH: begin
                    r_width <= n_dim;
                end
                REG_HEIGHT: begin
                    r_height <= n_dim;
                end
                REG_COLOR: begin
                    r_color <= pwdata[COLOR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback, unmapped index reads zero
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_BITS'(r_width);
            REG_HEIGHT: prdata = PDATA_BITS'(r_height);
            REG_COLOR:  prdata = PDATA_BITS'(r_color);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = r_width;
    assign cfg.height = r_height;
    assign cfg.color  = r_color;

    // front end: takes requests and precomputes the line increments
    blpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    // short queue decouples request intake from pixel output stalls
    blpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    // back end: stepping recurrence, clipping, framebuffer offset
    blpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_active    (pix_active),
        .o_write_en  (pix_we),
        .o_offset    (pix_offset),
        .o_color     (pix_color),
        .o_last      (pix_last)
    );

    // pack result, lowest field first, zero padded to whole bytes
    assign m_axis_tdata = OUT_TDATA_BITS'({pix_color, pix_offset, pix_we, pix_active});
    assign m_axis_tlast = pix_last;

endmodule

// File: rtl/core/blpg_front.sv
// blpg_front: accepts requests, classifies load/step and precomputes line increments
// depends on blpg_pkg
module blpg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic [blpg_pkg::IN_TDATA_BITS-1:0] i_data,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output blpg_pkg::t_cmd                  o_cmd
);
    import blpg_pkg::*;

    logic                         r_valid;
    t_cmd                         r_cmd;
    t_cmd                         n_cmd;
    logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
    logic signed [COORD_BITS:0]   dw, dh;
    logic signed [INC_BITS-1:0]   dh2;

    assign xs = $signed(i_data[COORD_BITS-1:0]);
    assign ys = $signed(i_data[2*COORD_BITS-1:COORD_BITS]);
    assign xe = $signed(i_data[3*COORD_BITS-1:2*COORD_BITS]);
    assign ye = $signed(i_data[4*COORD_BITS-1:3*COORD_BITS]);

    always_comb begin
        dw  = (COORD_BITS+1)'(xe) - (COORD_BITS+1)'(xs);
        dh  = (COORD_BITS+1)'(ye) - (COORD_BITS+1)'(ys);
        dh2 = INC_BITS'(dh) <<< 1;
        n_cmd.is_load  = (t_opcode'(i_opcode) == OP_LOAD);
        n_cmd.nonempty = (xe >= xs);
        n_cmd.xs       = xs;
        n_cmd.ys       = ys;
        n_cmd.xe       = xe;
        n_cmd.inc_s    = dh2;
        n_cmd.inc_d    = dh2 - (INC_BITS'(dw) <<< 1);
        n_cmd.err0     = dh2 - INC_BITS'(dw);
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/core/blpg_queue.sv
// blpg_queue: short request queue between front end and back end
// depends on blpg_pkg
module blpg_queue #(
    parameter int DEPTH = blpg_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  blpg_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output blpg_pkg::t_cmd o_cmd
);
    import blpg_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_cmd                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                push, pop;

    assign o_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/blpg_back.sv
// blpg_back: line state update, clipping, offset arithmetic and output register
// depends on blpg_pkg
module blpg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  blpg_pkg::t_cfg                       i_cfg,
    input  logic                                 i_cmd_valid,
    output logic                                 o_cmd_ready,
    input  blpg_pkg::t_cmd                       i_cmd,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_active,
    output logic                                 o_write_en,
    output logic [blpg_pkg::OFFSET_BITS-1:0]     o_offset,
    output logic [blpg_pkg::COLOR_BITS-1:0]      o_color,
    output logic                                 o_last
);
    import blpg_pkg::*;

    logic en, pop;

    // line state
    logic                       r_busy, n_busy;
    logic signed [X_BITS-1:0]   r_cur_x, n_cur_x;
    logic signed [Y_BITS-1:0]   r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0]      r_end_x, n_end_x;
    logic [ERR_BITS-1:0]        r_err, n_err;
    logic [INC_BITS-1:0]        r_inc_s, n_inc_s;
    logic [INC_BITS-1:0]        r_inc_d, n_inc_d;

    // stage a: pixel position
    logic                       r_a_valid, r_a_active, r_a_last;
    logic                       n_a_active, n_a_last, step_last;
    logic signed [X_BITS-1:0]   r_a_x;
    logic signed [Y_BITS-1:0]   r_a_y;

    // stage b: clip and products
    logic                       r_b_valid, r_b_active, r_b_last, r_b_vis;
    logic signed [X_BITS-1:0]   r_b_x;
    logic signed [WY_BITS-1:0]  r_b_wy;
    logic [AREA_BITS-1:0]       r_b_area;
    logic [DIM_BITS-1:0]        r_b_whalf;
    logic [X_BITS-1:0]          abs_x;
    logic [Y_BITS-1:0]          abs_y;
    logic                       n_vis;

    // stage c: output register
    logic                       r_c_valid, r_c_active, r_c_we, r_c_last;
    logic [OFFSET_BITS-1:0]     r_c_offset, n_offset;
    logic [COLOR_BITS-1:0]      r_c_color;

    assign en          = !r_c_valid || i_ready;
    assign pop         = en && i_cmd_valid;
    assign o_cmd_ready = en;

    always_comb begin
        n_busy     = r_busy;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_end_x    = r_end_x;
        n_err      = r_err;
        n_inc_s    = r_inc_s;
        n_inc_d    = r_inc_d;
        n_a_active = 1'b0;
        n_a_last   = 1'b0;
        step_last  = (r_cur_x == X_BITS'($signed(r_end_x)));
        if (i_cmd.is_load) begin
            n_cur_x  = X_BITS'($signed(i_cmd.xs));
            n_cur_y  = Y_BITS'($signed(i_cmd.ys));
            n_end_x  = i_cmd.xe;
            n_inc_s  = i_cmd.inc_s;
            n_inc_d  = i_cmd.inc_d;
            n_err    = ERR_BITS'($signed(i_cmd.err0));
            n_busy   = i_cmd.nonempty;
            n_a_last = !i_cmd.nonempty;
        end else if (r_busy) begin
            n_a_active = 1'b1;
            n_a_last   = step_last;
            // negative error: straight step, else diagonal step
            if (r_err[ERR_BITS-1]) begin
                n_err = r_err + ERR_BITS'($signed(r_inc_s));
            end else begin
                n_err   = r_err + ERR_BITS'($signed(r_inc_d));
                n_cur_y = r_cur_y + Y_BITS'(1);
            end
            n_cur_x = r_cur_x + X_BITS'(1);
            if (step_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        abs_x = r_a_x[X_BITS-1] ? X_BITS'(0) - X_BITS'(r_a_x) : X_BITS'(r_a_x);
        abs_y = r_a_y[Y_BITS-1] ? Y_BITS'(0) - Y_BITS'(r_a_y) : Y_BITS'(r_a_y);
        n_vis = r_a_active
             && (abs_x < X_BITS'(i_cfg.width >> 1))
             && (abs_y < Y_BITS'(i_cfg.height >> 1));
        n_offset = OFFSET_BITS'(r_b_area >> 1) + OFFSET_BITS'(r_b_whalf)
                 + OFFSET_BITS'(r_b_x) - OFFSET_BITS'(r_b_wy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            if (pop) begin
                r_busy <= n_busy;
            end
            r_a_valid <= pop;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        if (en) begin
            if (pop) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_end_x <= n_end_x;
                r_err   <= n_err;
                r_inc_s <= n_inc_s;
                r_inc_d <= n_inc_d;
            end
            r_a_active <= n_a_active;
            r_a_last   <= n_a_last;
            r_a_x      <= r_cur_x;
            r_a_y      <= r_cur_y;

            r_b_active <= r_a_active;
            r_b_last   <= r_a_last;
            r_b_vis    <= n_vis;
            r_b_x      <= r_a_x;
            r_b_wy     <= WY_BITS'($signed({1'b0, i_cfg.width})) * WY_BITS'(r_a_y);
            r_b_area   <= AREA_BITS'(i_cfg.width) * AREA_BITS'(i_cfg.height);
            r_b_whalf  <= i_cfg.width >> 1;

            r_c_active <= r_b_active;
            r_c_we     <= r_b_vis;
            r_c_last   <= r_b_last;
            r_c_offset <= r_b_vis ? n_offset : '0;
            r_c_color  <= r_b_vis ? i_cfg.color : '0;
        end
    end

    assign o_valid    = r_c_valid;
    assign o_active   = r_c_active;
    assign o_write_en = r_c_we;
    assign o_offset   = r_c_offset;
    assign o_color    = r_c_color;
    assign o_last     = r_c_last;

endmodule

// File: tb/tb.sv
// tb: self-checking bench for the first-octant line pixel generator core
// drives request and register ports, predicts every pixel result and compares in order
// depends on blpg_pkg and bresenham_line_pixel_gen_core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blpg_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 12;    // margin past the core pipeline depth
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 80;    // long receiver stall to fill the core
    localparam int PRINT_CAP      = 100;

    // one pixel result as seen on the output stream
    typedef struct packed {
        bit        active;
        bit        visible;
        bit [21:0] offset;
        bit [31:0] color;
        bit        last;
    } pixel_t;

    localparam pixel_t NO_PIXEL = '0;

    // directed stimulus row; typed rows carry their own expected result
    typedef struct packed {
        t_opcode op;
        int      xs;
        int      ys;
        int      xe;
        int      ye;
        bit      typed;
        pixel_t  res;
    } stim_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // x_start, y_start, x_end, y_end (12 bits each, signed)
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    // opcode
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // pixel_active, write_enable, pixel_offset (22), pixel_color (32)
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    // last_pixel
    logic                      m_axis_tlast;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_BITS-1:0]     paddr = '0;
    logic [PDATA_BITS-1:0]     pwdata = '0;
    logic [PDATA_BITS-1:0]     prdata;
    logic                      pready;

    bresenham_line_pixel_gen_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // screen settings as the core should hold them
    int unsigned cfg_width  = 640;
    int unsigned cfg_height = 480;
    bit [31:0]   cfg_color  = '0;

    // line walker state
    int        pen_x;
    int        pen_y;
    int        stop_x;
    bit [31:0] bres_err;
    int        bump_flat;
    int        bump_diag;
    bit        drawing;

    pixel_t expected_pixels[$];

    bit gaps_on      = 1'b1;   // both sides idle at random while set
    int hold_request = 0;      // receiver picks this up as one long stall

    int mismatch_count = 0;
    int results_seen   = 0;
    int active_items   = 0;    // loads and steps of a live line
    int n_loads        = 0;
    int n_pixels       = 0;
    int n_visible      = 0;
    int n_reg_writes   = 0;
    int quiet_cycles   = 0;

    // ---------------------------------------------------------------
    // pixel predictor: one result per request, walker state advanced
    // ---------------------------------------------------------------
    function automatic pixel_t predict_pixel(input t_opcode op, input logic [11:0] xs,
                                             input logic [11:0] ys, input logic [11:0] xe,
                                             input logic [11:0] ye);
        pixel_t res;
        int     ixs, iys, ixe, iye, dx, dy;
        longint sw, sh, px, py, off;
        res = NO_PIXEL;
        if (op == OP_LOAD) begin
            ixs = $signed(xs);
            iys = $signed(ys);
            ixe = $signed(xe);
            iye = $signed(ye);
            dx  = ixe - ixs;
            dy  = iye - iys;
            pen_x     = ixs;
            pen_y     = iys;
            stop_x    = ixe;
            bump_flat = 2 * dy;
            bump_diag = 2 * (dy - dx);
            bres_err  = 2 * dy - dx;
            drawing   = (ixe >= ixs);
            // a backwards line is done the moment it is loaded
            res.last  = !drawing;
            n_loads++;
            active_items++;
        end else if (drawing) begin
            sw = cfg_width;
            sh = cfg_height;
            px = pen_x;
            py = pen_y;
            res.active = 1'b1;
            // clip against the centred screen, half sizes round down
            if ((px < 0 ? -px : px) < sw / 2 && (py < 0 ? -py : py) < sh / 2) begin
                off = (sw * sh) / 2 + sw / 2 + px - sw * py;
                res.visible = 1'b1;
                res.offset  = off[21:0];
                res.color   = cfg_color;
                n_visible++;
            end
            res.last = (pen_x == stop_x);
            // sign of the error picks a straight or a diagonal move
            if (bres_err[31]) begin
                bres_err += bump_flat;
            end else begin
                pen_y++;
                bres_err += bump_diag;
            end
            pen_x++;
            if (res.last) drawing = 1'b0;
            n_pixels++;
            active_items++;
        end
        return res;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                     $realtime, results_seen, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    // valid stays high across back-to-back requests, lowered only for a gap
    task automatic send_request(input t_opcode op, input logic [11:0] xs,
                                input logic [11:0] ys, input logic [11:0] xe,
                                input logic [11:0] ye, input bit use_typed,
                                input pixel_t typed_res);
        int     gap;
        pixel_t pred;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ye, xe, ys, xs};
        do @(posedge i_clk); while (!s_axis_tready);
        // predictor runs even for typed rows so the walker stays in step
        pred = predict_pixel(op, xs, ys, xe, ye);
        expected_pixels.push_back(use_typed ? typed_res : pred);
    endtask

    // step requests carry junk coordinates, the core must ignore them
    task automatic send_step();
        send_request(OP_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 1'b0, NO_PIXEL);
    endtask

    // wait for every expected pixel plus the pipeline depth
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup then access, only while the core is idle
    task automatic configure(input t_reg_idx idx, input logic [31:0] value);
        logic [11:0] dim;
        dim = (value[11:0] > MAX_DIM) ? 12'(MAX_DIM) : value[11:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = dim;
            REG_HEIGHT: cfg_height = dim;
            default:    cfg_color  = value;
        endcase
        n_reg_writes++;
    endtask

    // mostly well-formed lines near the screen, the rest junk loads and stray steps
    task automatic run_random_phase(input int target);
        int base, kind, len, steps, half_w, half_h, dy;
        int xs, ys, xe, ye;
        base = active_items;
        while (active_items - base < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 99);
            if (kind < 75) begin
                half_w = cfg_width / 2 + 3;
                half_h = cfg_height / 2 + 3;
                xs  = int'($urandom_range(0, 2 * half_w)) - half_w;
                ys  = int'($urandom_range(0, 2 * half_h)) - half_h;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                  : $urandom_range(0, 24);
                xe  = clamp_coord(xs + len);
                // some lines leave the first octant: steep or falling
                if ($urandom_range(0, 4) == 0)
                    dy = int'($urandom_range(0, 4 * len + 6)) - (2 * len + 3);
                else
                    dy = $urandom_range(0, len);
                ye  = clamp_coord(ys + dy);
                send_request(OP_LOAD, 12'(xs), 12'(ys), 12'(xe), 12'(ye), 1'b0, NO_PIXEL);
                steps = xe - xs + 1 + $urandom_range(0, 2);
                // now and then a line is cut short by the next load
                if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
                repeat (steps) send_step();
            end else if (kind < 90) begin
                send_request(OP_LOAD, 12'($urandom), 12'($urandom), 12'($urandom),
                             12'($urandom), 1'b0, NO_PIXEL);
                repeat ($urandom_range(0, 6)) send_step();
            end else begin
                repeat ($urandom_range(1, 3)) send_step();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // directed table, run with the reset screen of 640x480 and color 0
    // ---------------------------------------------------------------
    stim_row_t directed_rows [25] = '{
        // step with no line loaded gives an all-zero result
        '{OP_STEP,     0,     0,     0,     0, 1'b1, NO_PIXEL},
        // backwards line flags last on the load and draws nothing
        '{OP_LOAD,     5,     0,     3,     0, 1'b1, '{1'b0, 1'b0, 22'd0, 32'd0, 1'b1}},
        '{OP_STEP,     0,     0,     0,     0, 1'b1, NO_PIXEL},
        // single-pixel line at the screen centre
        '{OP_LOAD,     0,     0,     0,     0, 1'b1, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b1, '{1'b1, 1'b1, 22'd153920, 32'd0, 1'b1}},
        '{OP_STEP,     0,     0,     0,     0, 1'b1, NO_PIXEL},
        // full-range diagonal, first pixel far off screen
        '{OP_LOAD, -2048, -2048,  2047,  2047, 1'b1, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b1, '{1'b1, 1'b0, 22'd0, 32'd0, 1'b0}},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        // full-range backwards line replaces the live one
        '{OP_LOAD,  2047,  2047, -2048, -2048, 1'b1, '{1'b0, 1'b0, 22'd0, 32'd0, 1'b1}},
        // bottom-left corner just inside the clip window
        '{OP_LOAD,  -319,  -239,  -317,  -237, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        // top-right corner: second pixel crosses the clip edge
        '{OP_LOAD,   319,   239,   320,   239, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        // steep line, recurrence runs uncorrected
        '{OP_LOAD,     0,     0,     2,  2047, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        // falling line, abandoned before its end
        '{OP_LOAD,     0,     0,     3,   -10, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL},
        '{OP_STEP,     0,     0,     0,     0, 1'b0, NO_PIXEL}
    };

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, 12'(directed_rows[i].xs),
                         12'(directed_rows[i].ys), 12'(directed_rows[i].xe),
                         12'(directed_rows[i].ye), directed_rows[i].typed,
                         directed_rows[i].res);
        settle();

        // largest screen, all-ones color: offsets wrap at 22 bits
        configure(REG_WIDTH, 32'd2048);
        configure(REG_HEIGHT, 32'd2048);
        configure(REG_COLOR, 32'hFFFF_FFFF);
        run_random_phase(200);
        settle();

        // oversized width saturates, height at its lowest legal value
        configure(REG_WIDTH, 32'd4095);
        configure(REG_HEIGHT, 32'd2);
        configure(REG_COLOR, $urandom);
        run_random_phase(175);
        settle();

        // tiny height: nothing visible; long receiver stall backs up the core
        configure(REG_WIDTH, 32'd2);
        configure(REG_HEIGHT, 32'd1);
        configure(REG_COLOR, 32'd0);
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        send_request(OP_LOAD, -12'sd100, 12'd0, 12'd200, 12'd5, 1'b0, NO_PIXEL);
        repeat (40) send_step();
        run_random_phase(150);
        settle();

        // upper data bits dropped, zero height
        configure(REG_WIDTH, 32'h0000_1005);
        configure(REG_HEIGHT, 32'd0);
        configure(REG_COLOR, $urandom);
        run_random_phase(100);
        settle();

        // random screens
        repeat (4) begin
            configure(REG_WIDTH, $urandom_range(2, 2048));
            configure(REG_HEIGHT, $urandom_range(2, 2048));
            configure(REG_COLOR, $urandom);
            run_random_phase(175);
            settle();
        end

        $display("summary: %0d line loads, %0d pixels stepped, %0d of them on screen",
                 n_loads, n_pixels, n_visible);
        $display("summary: %0d results compared across %0d register writes",
                 results_seen, n_reg_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // result side: random stalls, in-order compare against the queue
    // ---------------------------------------------------------------
    initial begin : pixel_sink
        int     stall;
        pixel_t got, want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.active  = m_axis_tdata[0];
            got.visible = m_axis_tdata[1];
            got.offset  = m_axis_tdata[23:2];
            got.color   = m_axis_tdata[55:24];
            got.last    = m_axis_tlast;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (got.active != want.active)
                    report_mismatch("pixel_active", got.active, want.active);
                if (got.visible != want.visible)
                    report_mismatch("write_enable", got.visible, want.visible);
                if (got.offset != want.offset)
                    report_mismatch("pixel_offset", got.offset, want.offset);
                if (got.color != want.color)
                    report_mismatch("pixel_color", got.color, want.color);
                if (got.last != want.last)
                    report_mismatch("last_pixel", got.last, want.last);
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: any handshake on either stream clears the count
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, expected_pixels.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// File: bresenham_line_pixel_gen_core.f
rtl/core/blpg_pkg.sv
rtl/core/blpg_front.sv
rtl/core/blpg_queue.sv
rtl/core/blpg_back.sv
rtl/core/bresenham_line_pixel_gen_core.sv
tb/tb.sv
